@@ src/prr_pkg.sv @@
`timescale 1ns / 1ps

package prr_pkg;

	// Signed width for cell coordinates and candidate cells. It holds an
	// 11-bit point plus a ring offset of up to 256 cells, and it compares
	// against grid sizes of up to 4096 cells.
	localparam int COORD_W = 14;

	// Width in which the ring limit is saturated against MAX_RINGS.
	localparam int RING_CALC_W = 10;

	// Special cell costs.
	localparam logic [7:0] COST_INSCRIBED = 8'd253;
	localparam logic [7:0] COST_LETHAL    = 8'd254;
	localparam logic [7:0] COST_UNKNOWN   = 8'd255;

	// Configuration register indexes.
	localparam logic [1:0] CFG_GRID_WIDTH     = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT    = 2'd1;
	localparam logic [1:0] CFG_SEARCH_RINGS   = 2'd2;
	localparam logic [1:0] CFG_FREE_THRESHOLD = 2'd3;

	typedef enum logic [1:0] {
		ST_KEPT    = 2'd0,
		ST_MOVED   = 2'd1,
		ST_SKIPPED = 2'd2
	} status_t;

	// Datapath operation selected by one control word.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_READ_CENTER,
		OP_INIT_RING,
		OP_SCAN
	} op_t;

	// Condition that picks the next step.
	typedef enum logic [2:0] {
		CND_ACCEPT_CHECK,
		CND_OFF_GRID,
		CND_BLOCKED,
		CND_NO_RINGS,
		CND_SCAN_RUN,
		CND_HIT,
		CND_OUT_FREE
	} cond_t;

	typedef logic [3:0] upc_t;

	localparam upc_t UPC_IDLE   = 4'd0;
	localparam upc_t UPC_CHECK  = 4'd1;
	localparam upc_t UPC_CENTER = 4'd2;
	localparam upc_t UPC_RINGS  = 4'd3;
	localparam upc_t UPC_SCAN   = 4'd4;
	localparam upc_t UPC_DECIDE = 4'd5;
	localparam upc_t UPC_KEEP   = 4'd6;
	localparam upc_t UPC_MOVE   = 4'd7;
	localparam upc_t UPC_SKIP   = 4'd8;

	// Control outputs of the sequencer toward the datapath.
	typedef struct packed {
		logic    in_rdy;
		op_t     op;
		logic    emit;
		status_t emit_status;
	} ctrl_t;

	// Status flags from the datapath toward the sequencer.
	typedef struct packed {
		logic accept_check;
		logic off_grid;
		logic blocked;
		logic no_rings;
		logic scan_run;
		logic hit;
		logic out_free;
	} flags_t;

	typedef struct packed {
		ctrl_t ctrl;
		cond_t cond;
		upc_t  tgt_true;
		upc_t  tgt_false;
	} uword_t;

	// The microprogram. Each step issues its control and branches on one flag.
	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		w = '{ctrl: '{in_rdy: 1'b0, op: OP_NONE, emit: 1'b0, emit_status: ST_SKIPPED},
			cond: CND_OUT_FREE, tgt_true: UPC_IDLE, tgt_false: UPC_IDLE};
		case (pc)
			UPC_IDLE: begin
				w.ctrl.in_rdy = 1'b1;
				w.ctrl.op = OP_LOAD;
				w.cond = CND_ACCEPT_CHECK;
				w.tgt_true = UPC_CHECK;
				w.tgt_false = UPC_IDLE;
			end
			UPC_CHECK: begin
				w.ctrl.op = OP_READ_CENTER;
				w.cond = CND_OFF_GRID;
				w.tgt_true = UPC_SKIP;
				w.tgt_false = UPC_CENTER;
			end
			UPC_CENTER: begin
				w.ctrl.op = OP_INIT_RING;
				w.cond = CND_BLOCKED;
				w.tgt_true = UPC_RINGS;
				w.tgt_false = UPC_KEEP;
			end
			UPC_RINGS: begin
				w.cond = CND_NO_RINGS;
				w.tgt_true = UPC_SKIP;
				w.tgt_false = UPC_SCAN;
			end
			UPC_SCAN: begin
				w.ctrl.op = OP_SCAN;
				w.cond = CND_SCAN_RUN;
				w.tgt_true = UPC_SCAN;
				w.tgt_false = UPC_DECIDE;
			end
			UPC_DECIDE: begin
				w.cond = CND_HIT;
				w.tgt_true = UPC_MOVE;
				w.tgt_false = UPC_SKIP;
			end
			UPC_KEEP: begin
				w.ctrl.emit = 1'b1;
				w.ctrl.emit_status = ST_KEPT;
				w.cond = CND_OUT_FREE;
				w.tgt_true = UPC_IDLE;
				w.tgt_false = UPC_KEEP;
			end
			UPC_MOVE: begin
				w.ctrl.emit = 1'b1;
				w.ctrl.emit_status = ST_MOVED;
				w.cond = CND_OUT_FREE;
				w.tgt_true = UPC_IDLE;
				w.tgt_false = UPC_MOVE;
			end
			UPC_SKIP: begin
				w.ctrl.emit = 1'b1;
				w.ctrl.emit_status = ST_SKIPPED;
				w.cond = CND_OUT_FREE;
				w.tgt_true = UPC_IDLE;
				w.tgt_false = UPC_SKIP;
			end
			default: begin
				w.cond = CND_OUT_FREE;
				w.tgt_true = UPC_IDLE;
				w.tgt_false = UPC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

@@ src/prr_seq.sv @@
`timescale 1ns / 1ps

module prr_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  prr_pkg::flags_t flags,
	output prr_pkg::ctrl_t  ctrl
);
	import prr_pkg::*;

	upc_t   pc_q;
	uword_t word;
	logic   take;

	always_comb begin
		word = ucode_rom(pc_q);
		case (word.cond)
			CND_ACCEPT_CHECK: take = flags.accept_check;
			CND_OFF_GRID:     take = flags.off_grid;
			CND_BLOCKED:      take = flags.blocked;
			CND_NO_RINGS:     take = flags.no_rings;
			CND_SCAN_RUN:     take = flags.scan_run;
			CND_HIT:          take = flags.hit;
			CND_OUT_FREE:     take = flags.out_free;
			default:          take = 1'b0;
		endcase
	end

	assign ctrl = word.ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_IDLE;
		end else begin
			pc_q <= take ? word.tgt_true : word.tgt_false;
		end
	end

endmodule

@@ src/path_point_repair_ring_search_unit.sv @@
`timescale 1ns / 1ps
// Sequence: a grid write is stored at its accepting edge and returns no word. A check has
// its result word registered after the off-grid test for an off-grid point, after the
// center test for a kept point, after the ring test with no rings, or after the ring search.
// Throughput: one grid write per cycle; a check blocks input until its result word is
// registered, since the scan reads one ring border cell per cycle through one port.
// Reset clears the sequencer, the output valid and the config registers, not the grid.

module path_point_repair_ring_search_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RINGS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [10:0] cell_x,
	input  logic [10:0] cell_y,
	input  logic [7:0]  cell_cost,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  out_x,
	output logic [7:0]  out_y,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata
);
	import prr_pkg::*;

	// Address bits along each axis; a cell sits at {y, x}.
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	// Ring counter and signed ring offsets.
	localparam int RW = $clog2(MAX_RINGS + 1);
	localparam int DW = RW + 1;

	// Configuration registers.
	logic [8:0] grid_width_q;
	logic [8:0] grid_height_q;
	logic [6:0] search_rings_q;
	logic [7:0] free_threshold_q;

	// Saturated limits in use.
	logic [COORD_W-1:0]     wlim;
	logic [COORD_W-1:0]     hlim;
	logic [RING_CALC_W-1:0] rlim_ext;
	logic [RW-1:0]          rmax;

	// Point under check and scan iterator.
	logic signed [10:0]   px_q;
	logic signed [10:0]   py_q;
	logic [RW-1:0]        r_q;
	logic signed [DW-1:0] dx_q;
	logic signed [DW-1:0] dy_q;
	logic                 done_q;

	// Cell whose read is in flight during the scan.
	logic       rd_vld_s1;
	logic [7:0] rd_x_s1;
	logic [7:0] rd_y_s1;

	// Cost grid with a registered read port.
	logic [7:0] grid_mem [2**AW];
	logic [7:0] rdata_q;

	// Output register.
	logic       out_valid_q;
	status_t    status_q;
	logic [7:0] out_x_q;
	logic [7:0] out_y_q;

	ctrl_t  ctrl;
	flags_t flags;

	logic                      in_acc;
	logic signed [COORD_W-1:0] in_x;
	logic signed [COORD_W-1:0] in_y;
	logic signed [COORD_W-1:0] pt_x;
	logic signed [COORD_W-1:0] pt_y;
	logic signed [COORD_W-1:0] cand_x;
	logic signed [COORD_W-1:0] cand_y;
	logic                      cand_on;
	logic                      pt_on;
	logic                      in_on;
	logic signed [DW-1:0]      r_s;
	logic                      col_edge;
	logic                      issue;
	logic                      hit;
	logic                      blocked;
	logic                      out_free;
	logic                      mem_we;
	logic                      mem_re;
	logic [AW-1:0]             waddr;
	logic [AW-1:0]             raddr;

	function automatic logic on_grid(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y,
			input logic [COORD_W-1:0] wl,
			input logic [COORD_W-1:0] hl);
		logic ok;
		ok = !x[COORD_W-1] && !y[COORD_W-1] && ($unsigned(x) < wl) && ($unsigned(y) < hl);
		return ok;
	endfunction

	// Grid sizes and the ring limit saturate to the built-in maxima.
	always_comb begin
		wlim = (COORD_W'(grid_width_q) > COORD_W'(MAX_WIDTH)) ?
			COORD_W'(MAX_WIDTH) : COORD_W'(grid_width_q);
		hlim = (COORD_W'(grid_height_q) > COORD_W'(MAX_HEIGHT)) ?
			COORD_W'(MAX_HEIGHT) : COORD_W'(grid_height_q);
		rlim_ext = (RING_CALC_W'(search_rings_q) > RING_CALC_W'(MAX_RINGS)) ?
			RING_CALC_W'(MAX_RINGS) : RING_CALC_W'(search_rings_q);
		rmax = rlim_ext[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q     <= 9'd256;
			grid_height_q    <= 9'd256;
			search_rings_q   <= 7'd10;
			free_threshold_q <= 8'd253;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:     grid_width_q <= cfg_wdata;
				CFG_GRID_HEIGHT:    grid_height_q <= cfg_wdata;
				CFG_SEARCH_RINGS:   search_rings_q <= cfg_wdata[6:0];
				CFG_FREE_THRESHOLD: free_threshold_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// The sequencer holds the step counter and the control store.
	prr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign in_stall = !ctrl.in_rdy;
	assign in_acc = in_valid && ctrl.in_rdy;

	always_comb begin
		in_x = COORD_W'($signed(cell_x));
		in_y = COORD_W'($signed(cell_y));
		pt_x = COORD_W'(px_q);
		pt_y = COORD_W'(py_q);
		cand_x = pt_x + COORD_W'(dx_q);
		cand_y = pt_y + COORD_W'(dy_q);
		in_on = on_grid(in_x, in_y, wlim, hlim);
		pt_on = on_grid(pt_x, pt_y, wlim, hlim);
		cand_on = on_grid(cand_x, cand_y, wlim, hlim);
		r_s = $signed({1'b0, r_q});
		col_edge = (dx_q == r_s) || (dx_q == -r_s);
	end

	// A candidate cell wins when its read was issued and its cost is below the threshold.
	assign hit = rd_vld_s1 && (rdata_q < free_threshold_q);
	// A new scan position is taken only while nothing has been found and positions remain.
	assign issue = (ctrl.op == OP_SCAN) && !hit && !done_q;
	assign blocked = (rdata_q == COST_LETHAL) || (rdata_q == COST_INSCRIBED) ||
		(rdata_q == COST_UNKNOWN);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		flags.accept_check = in_acc && cmd;
		flags.off_grid = !pt_on;
		flags.blocked = blocked;
		flags.no_rings = (rmax == '0);
		flags.scan_run = !hit && !done_q;
		flags.hit = hit;
		flags.out_free = out_free;
	end

	// Grid port: writes happen only at accept time, reads only while checking.
	always_comb begin
		mem_we = in_acc && !cmd && in_on;
		waddr = {in_y[YW-1:0], in_x[XW-1:0]};
		mem_re = ((ctrl.op == OP_READ_CENTER) && pt_on) || (issue && cand_on);
		if (ctrl.op == OP_READ_CENTER) begin
			raddr = {pt_y[YW-1:0], pt_x[XW-1:0]};
		end else begin
			raddr = {cand_y[YW-1:0], cand_x[XW-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[waddr] <= cell_cost;
		end
		if (mem_re) begin
			rdata_q <= grid_mem[raddr];
		end
	end

	// Point capture and the ring walk. The walk visits only ring border cells:
	// in an inner column the bottom cell is followed straight by the top one.
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_LOAD && in_acc) begin
			px_q <= $signed(cell_x);
			py_q <= $signed(cell_y);
		end
		if (issue) begin
			rd_x_s1 <= cand_x[7:0];
			rd_y_s1 <= cand_y[7:0];
		end
		case (ctrl.op)
			OP_INIT_RING: begin
				r_q  <= RW'(1);
				dx_q <= -DW'(1);
				dy_q <= -DW'(1);
			end
			OP_SCAN: begin
				if (issue) begin
					if (dy_q == r_s) begin
						if (dx_q == r_s) begin
							if (r_q != rmax) begin
								r_q  <= r_q + RW'(1);
								dx_q <= -(r_s + DW'(1));
								dy_q <= -(r_s + DW'(1));
							end
						end else begin
							dx_q <= dx_q + DW'(1);
							dy_q <= -r_s;
						end
					end else if (col_edge) begin
						dy_q <= dy_q + DW'(1);
					end else begin
						dy_q <= r_s;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_INIT_RING: begin
					done_q    <= 1'b0;
					rd_vld_s1 <= 1'b0;
				end
				OP_SCAN: begin
					// Freeze the in-flight cell once it hits, so its coordinates survive.
					if (!hit) begin
						rd_vld_s1 <= issue && cand_on;
					end
					if (issue && (dy_q == r_s) && (dx_q == r_s) && (r_q == rmax)) begin
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result word register; it takes a new word whenever the old one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			status_q <= ctrl.emit_status;
			case (ctrl.emit_status)
				ST_KEPT: begin
					out_x_q <= pt_x[7:0];
					out_y_q <= pt_y[7:0];
				end
				ST_MOVED: begin
					out_x_q <= rd_x_s1;
					out_y_q <= rd_y_s1;
				end
				default: begin
					out_x_q <= 8'd0;
					out_y_q <= 8'd0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;

endmodule

@@ tb/ring_repair_checker.sv @@
`timescale 1ns / 1ps

package repair_tb_pkg;

	// Operation carried by the cmd bit of an input word.
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_CHECK = 1'b1
	} cmd_t;

endpackage

module ring_repair_checker #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RINGS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cmd,
	input  logic [10:0] cell_x,
	input  logic [10:0] cell_y,
	input  logic [7:0]  cell_cost,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [7:0]  out_x,
	input  logic [7:0]  out_y,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata,
	output int          fail_count,
	output int          pending
);

	import prr_pkg::*;
	import repair_tb_pkg::*;

	typedef struct packed {
		status_t    verdict;
		logic [7:0] x;
		logic [7:0] y;
	} repair_t;

	repair_t    expected_repairs[$];
	logic [7:0] cost_map [0:MAX_WIDTH*MAX_HEIGHT-1];
	logic [8:0] width_reg;
	logic [8:0] height_reg;
	logic [6:0] rings_reg;
	logic [7:0] thr_reg;

	// Sizes above the build limits saturate, so the cells in use never leave the array.
	function automatic bit on_map(input int x, input int y);
		int uw;
		int uh;
		uw = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		uh = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		return x >= 0 && y >= 0 && x < uw && y < uh;
	endfunction

	function automatic repair_t repair_point(input logic [10:0] raw_x, input logic [10:0] raw_y);
		int         px;
		int         py;
		int         span;
		int         r;
		int         dx;
		int         dy;
		int         qx;
		int         qy;
		logic [7:0] centre;
		repair_t    res;
		px = $signed(raw_x);
		py = $signed(raw_y);
		res = '{verdict: ST_SKIPPED, x: 8'd0, y: 8'd0};
		if (!on_map(px, py))
			return res;
		centre = cost_map[py * MAX_WIDTH + px];
		if (centre != COST_LETHAL && centre != COST_INSCRIBED && centre != COST_UNKNOWN) begin
			res = '{verdict: ST_KEPT, x: px[7:0], y: py[7:0]};
			return res;
		end
		// Walk the ring borders outward; the first free cell in scan order wins.
		span = (rings_reg > MAX_RINGS) ? MAX_RINGS : rings_reg;
		for (r = 1; r <= span; r++) begin
			for (dx = -r; dx <= r; dx++) begin
				for (dy = -r; dy <= r; dy++) begin
					qx = px + dx;
					qy = py + dy;
					if ((dx == r || dx == -r || dy == r || dy == -r) && on_map(qx, qy)
							&& cost_map[qy * MAX_WIDTH + qx] < thr_reg) begin
						res = '{verdict: ST_MOVED, x: qx[7:0], y: qy[7:0]};
						return res;
					end
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg <= 9'd256;
			height_reg <= 9'd256;
			rings_reg <= 7'd10;
			thr_reg <= 8'd253;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH: begin
					width_reg <= cfg_wdata;
				end
				CFG_GRID_HEIGHT: begin
					height_reg <= cfg_wdata;
				end
				CFG_SEARCH_RINGS: begin
					rings_reg <= cfg_wdata[6:0];
				end
				CFG_FREE_THRESHOLD: begin
					thr_reg <= cfg_wdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always @(posedge clk) begin : watch
		repair_t want;
		int      wx;
		int      wy;
		if (!arst_n) begin
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_repairs.size() == 0) begin
					fail_count = fail_count + 1;
					$display("%0t: expected no word, got status %0d x %0d y %0d",
						$time, status, out_x, out_y);
				end else begin
					want = expected_repairs.pop_front();
					if (status !== want.verdict || out_x !== want.x || out_y !== want.y) begin
						fail_count = fail_count + 1;
						$display("%0t: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
							$time, want.verdict, want.x, want.y, status, out_x, out_y);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE) begin
					wx = $signed(cell_x);
					wy = $signed(cell_y);
					if (on_map(wx, wy))
						cost_map[wy * MAX_WIDTH + wx] = cell_cost;
				end else begin
					expected_repairs.insert(expected_repairs.size(),
						repair_point(cell_x, cell_y));
				end
			end
			pending = expected_repairs.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	import prr_pkg::*;
	import repair_tb_pkg::*;

	localparam int GRID_MAX       = 256;
	localparam int RING_MAX       = 64;
	localparam int IDLE_PCT       = 34;
	localparam int RESET_CYCLES   = 8;
	// Corner region that is written in full before any random check; every grid
	// in use during random traffic lies inside it.
	localparam int FILL_W         = 16;
	localparam int FILL_H         = 12;
	// A grid write is stored at its accepting edge, so a short pause makes the block idle
	// before a register is written.
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 500;
	// A search at the saturated ring limit accepts nothing while it runs, so the
	// watchdog limit is set to outlast it.
	localparam int WATCHDOG_LIMIT = 100000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [10:0] cell_x;
	logic [10:0] cell_y;
	logic [7:0]  cell_cost;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  out_x;
	logic [7:0]  out_y;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_wdata;

	int mismatches;
	int pending;
	int quiet_cycles;

	// While calm is set neither side inserts idle cycles.
	logic calm;
	// Copies of the current settings, used to aim coordinates and costs.
	int   used_w;
	int   used_h;
	int   free_thr;

	path_point_repair_ring_search_unit #(
		.MAX_WIDTH(GRID_MAX),
		.MAX_HEIGHT(GRID_MAX),
		.MAX_RINGS(RING_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.cell_cost(cell_cost),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_x(out_x),
		.out_y(out_y),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	ring_repair_checker #(
		.MAX_WIDTH(GRID_MAX),
		.MAX_HEIGHT(GRID_MAX),
		.MAX_RINGS(RING_MAX)
	) repair_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.cell_cost(cell_cost),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_x(out_x),
		.out_y(out_y),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The result side stalls at random, one decision per cycle on the falling edge.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Ends the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one input word and returns at the falling edge after it was taken.
	// Valid stays high on return, so the next call either keeps it up or drops it
	// for a gap, and the line gets a single update per edge.
	task automatic push_word(input cmd_t op, input int x, input int y, input int cost);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		cell_x <= x[10:0];
		cell_y <= y[10:0];
		cell_cost <= cost[7:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data[8:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Registers change only while the block is idle: every check answered and
	// the last grid write retired.
	task automatic set_config(input int w, input int h, input int rings, input int thr);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_GRID_WIDTH, w);
		write_reg(CFG_GRID_HEIGHT, h);
		write_reg(CFG_SEARCH_RINGS, rings);
		write_reg(CFG_FREE_THRESHOLD, thr);
		used_w = (w > GRID_MAX) ? GRID_MAX : w;
		used_h = (h > GRID_MAX) ? GRID_MAX : h;
		free_thr = thr;
	endtask

	// Mostly on the grid in use, some just around its border, some anywhere in
	// the full signed range.
	function automatic int rand_coord(input int span);
		int pick;
		pick = $urandom_range(99);
		if (span > 0 && pick < 70)
			return $urandom_range(span - 1);
		else if (pick < 85)
			return $urandom_range(span + 3) - 2;
		return $urandom;
	endfunction

	function automatic int blocked_cost();
		return COST_INSCRIBED + $urandom_range(2);
	endfunction

	function automatic int free_cost();
		return (free_thr > 0) ? $urandom_range(free_thr - 1) : 0;
	endfunction

	// Most traffic is a patch of blocked cells written around a point, now and
	// then a free cell planted just outside it, and then a check of that point,
	// so that searches run past the first ring. The rest is loose writes and
	// checks anywhere.
	task automatic random_traffic(input int quota, input int calm_words);
		int sent;
		int pick;
		int cx;
		int cy;
		int k;
		int dx;
		int dy;
		sent = 0;
		while (sent < quota) begin
			calm = (sent < calm_words);
			pick = $urandom_range(99);
			if (pick < 20) begin
				push_word(CMD_WRITE, $urandom, $urandom, $urandom);
				sent++;
			end else if (pick < 35) begin
				push_word(CMD_CHECK, rand_coord(used_w), rand_coord(used_h), $urandom);
				sent++;
			end else begin
				cx = (used_w > 0) ? $urandom_range(used_w - 1) : rand_coord(used_w);
				cy = (used_h > 0) ? $urandom_range(used_h - 1) : rand_coord(used_h);
				k = ($urandom_range(9) == 0) ? 2 : $urandom_range(1);
				for (dx = -k; dx <= k; dx++) begin
					for (dy = -k; dy <= k; dy++) begin
						push_word(CMD_WRITE, cx + dx, cy + dy, blocked_cost());
						sent++;
					end
				end
				if ($urandom_range(1) == 1) begin
					dx = $urandom_range(2 * k + 2) - (k + 1);
					dy = ($urandom_range(1) == 1) ? k + 1 : -(k + 1);
					push_word(CMD_WRITE, cx + dx, cy + dy, free_cost());
					sent++;
				end
				// Sometimes the point itself is free again and is kept as is.
				if ($urandom_range(4) == 0) begin
					push_word(CMD_WRITE, cx, cy, free_cost());
					sent++;
				end
				push_word(CMD_CHECK, cx, cy, $urandom);
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		int x;
		int y;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_WRITE;
		cell_x = '0;
		cell_y = '0;
		cell_cost = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_GRID_WIDTH;
		cfg_wdata = '0;
		calm = 1'b1;
		used_w = GRID_MAX;
		used_h = GRID_MAX;
		free_thr = 253;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The grid holds no defined costs after reset, so the corner region used
		// by all random traffic is written before any check can read it. About
		// three cells in ten are blocked.
		for (y = 0; y < FILL_H; y++) begin
			for (x = 0; x < FILL_W; x++) begin
				pick = ($urandom_range(9) < 3) ? blocked_cost() : $urandom_range(252);
				push_word(CMD_WRITE, x, y, pick);
			end
		end
		calm = 1'b0;

		// Directed words at the reset settings; each check reads only cells that
		// were written before it. Free corner cells are kept, points off the grid
		// at the coordinate extremes are skipped, and writes off the grid are dropped.
		push_word(CMD_WRITE, 0, 0, 0);
		push_word(CMD_CHECK, 0, 0, 0);
		push_word(CMD_WRITE, 255, 255, 252);
		push_word(CMD_CHECK, 255, 255, 8'hFF);
		push_word(CMD_CHECK, -1024, 0, 0);
		push_word(CMD_CHECK, 1023, 1023, 0);
		push_word(CMD_CHECK, 256, 5, 0);
		push_word(CMD_CHECK, 5, 256, 0);
		push_word(CMD_CHECK, -1, -1, 0);
		push_word(CMD_WRITE, -1, 4, 7);
		push_word(CMD_WRITE, 256, 4, 7);
		push_word(CMD_WRITE, 255, 4, 9);
		push_word(CMD_CHECK, 255, 4, 0);
		// Each blocking cost at a center, two of them in corners where part of
		// the first ring lies off the grid; the first on-grid neighbor in scan
		// order is free, so the search stops there.
		push_word(CMD_WRITE, 0, 254, 0);
		push_word(CMD_WRITE, 0, 255, COST_UNKNOWN);
		push_word(CMD_CHECK, 0, 255, 0);
		push_word(CMD_WRITE, 254, 0, 3);
		push_word(CMD_WRITE, 255, 0, COST_LETHAL);
		push_word(CMD_CHECK, 255, 0, 0);
		push_word(CMD_WRITE, 128, 128, COST_INSCRIBED);
		push_word(CMD_WRITE, 127, 127, 0);
		push_word(CMD_CHECK, 128, 128, 0);

		set_config(FILL_W, FILL_H, 10, 253);
		random_traffic(200, 120);

		// Single cell, no rings and nothing counted as free.
		set_config(1, 1, 0, 0);
		push_word(CMD_CHECK, 0, 0, 0);
		push_word(CMD_CHECK, 1, 0, 0);
		push_word(CMD_CHECK, 0, 1, 0);
		random_traffic(40, 0);

		// No width at all: every write is dropped and every point skipped.
		set_config(0, 256, 3, 255);
		random_traffic(40, 0);

		// Oversized settings saturate to the full grid and the deepest ring limit.
		set_config(511, 300, 127, 255);
		push_word(CMD_CHECK, 255, 255, 0);
		push_word(CMD_CHECK, 256, 10, 0);
		push_word(CMD_CHECK, 0, 255, 0);

		// A tiny grid that is fully blocked makes the search run through all
		// rings before it gives up; then one free cell two rings out is found.
		set_config(3, 2, 127, 1);
		for (y = 0; y < 2; y++) begin
			for (x = 0; x < 3; x++)
				push_word(CMD_WRITE, x, y, blocked_cost());
		end
		push_word(CMD_CHECK, 1, 1, 0);
		push_word(CMD_CHECK, 0, 0, 0);
		push_word(CMD_WRITE, 2, 0, 0);
		push_word(CMD_CHECK, 0, 1, 0);

		set_config(14, 9, 5, 200);
		random_traffic(120, 0);

		set_config(FILL_W, 1, 2, 128);
		random_traffic(60, 0);

		set_config(FILL_W, FILL_H, 64, 253);
		random_traffic(100, 0);

		// Drain: wait for every answer, then watch for stray words a while longer.
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
